[rtl/fptm_pkg.sv]
// Shared constants, codes and a helper function for the four-level page table manager.
package fptm_pkg;

  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W = 9;
  localparam int FRAME_W = 40;
  localparam int ENTRY_W = 43;
  localparam int VA_W = 48;
  localparam int PA_W = 52;
  localparam int OFFSET_W = 12;

  localparam logic [1:0] CMD_MAP = 2'd0;
  localparam logic [1:0] CMD_UNMAP = 2'd1;
  localparam logic [1:0] CMD_TRANSLATE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  localparam logic [1:0] LVL_LEAF = 2'd3;

  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

[rtl/fptm_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module fptm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fptm_walker.sv]
// Table walk sequencer: clears the store, then walks, allocates and rewrites entries.
module fptm_walker import fptm_pkg::*; #(
  parameter int TABLE_PAGES = 64,
  parameter int ROOT_PAGES = 4,
  localparam int PW = $clog2(TABLE_PAGES),
  localparam int NW = $clog2(TABLE_PAGES + 1),
  localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [VA_W-1:0]    virt_addr,
  input  logic [PA_W-1:0]    phys_addr,
  input  logic               user_flag,
  input  logic               write_flag,
  input  logic [1:0]         root_page,
  output logic               done,
  output logic [1:0]         status,
  output logic [PA_W-1:0]    phys_result,
  output logic               leaf_present,
  output logic               leaf_user,
  output logic               leaf_write,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [ENTRY_W-1:0] ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  logic [ENTRY_W-1:0] ram_rdata
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EVAL  = 4'b1000
  } state_t;

  state_t           state;
  logic [AW-1:0]    clr_addr;
  logic [1:0]       cmd_r;
  logic [VA_W-1:0]  va_r;
  logic [PA_W-1:0]  pa_r;
  logic             usr_r;
  logic             wr_r;
  logic [1:0]       lvl;
  logic [PW-1:0]    page;
  logic             pass2;
  logic [NW-1:0]    nfp;

  logic [1:0]       root_mod;
  logic [PW-1:0]    root_pg;
  logic [AW-1:0]    acc_addr;
  logic             present;
  logic [PW-1:0]    frame_pg;
  logic [ENTRY_W-1:0] mid_entry;
  logic [ENTRY_W-1:0] leaf_entry;
  logic [1:0]       need;
  logic [NW:0]      need_sum;

  always_comb begin
    root_mod = root_page;
    for (int i = 0; i < 3; i++) begin
      if (int'(root_mod) >= ROOT_PAGES) begin
        root_mod = root_mod - 2'(ROOT_PAGES);
      end
    end
    root_pg = PW'(root_mod);
  end

  assign acc_addr = AW'({page, level_index(va_r, lvl)});
  assign present = ram_rdata[0];
  assign frame_pg = ram_rdata[3 +: PW];
  assign mid_entry = present ? {ram_rdata[ENTRY_W-1:3], usr_r, wr_r, 1'b1}
                             : {FRAME_W'(nfp), usr_r, wr_r, 1'b1};
  assign leaf_entry = {pa_r[PA_W-1:OFFSET_W], usr_r, wr_r, 1'b1};
  assign need = LVL_LEAF - lvl;
  assign need_sum = (NW+1)'(need) + (NW+1)'(nfp);

  assign busy = (state != S_IDLE);
  assign ram_raddr = acc_addr;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = acc_addr;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr;
      end
      S_EVAL: begin
        if (cmd_r == CMD_MAP && pass2) begin
          ram_we = 1'b1;
          ram_wdata = (lvl == LVL_LEAF) ? leaf_entry : mid_entry;
        end else if (cmd_r == CMD_UNMAP && lvl == LVL_LEAF) begin
          ram_we = 1'b1;
          ram_wdata = {ram_rdata[ENTRY_W-1:1], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      nfp <= NW'(ROOT_PAGES);
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (int'(clr_addr) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            va_r <= virt_addr;
            pa_r <= phys_addr;
            usr_r <= user_flag;
            wr_r <= write_flag;
            lvl <= '0;
            page <= root_pg;
            pass2 <= 1'b0;
            status <= ST_OK;
            phys_result <= '0;
            leaf_present <= 1'b0;
            leaf_user <= 1'b0;
            leaf_write <= 1'b0;
            if (cmd == CMD_MAP || cmd == CMD_UNMAP || cmd == CMD_TRANSLATE) begin
              state <= S_READ;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_READ;
          if (cmd_r == CMD_MAP && !pass2) begin
            if (!present || lvl == 2'd2) begin
              if (!present && need_sum > (NW+1)'(TABLE_PAGES)) begin
                status <= ST_EXHAUSTED;
                done <= 1'b1;
                state <= S_IDLE;
              end else begin
                pass2 <= 1'b1;
                lvl <= '0;
                page <= root_pg;
              end
            end else begin
              page <= frame_pg;
              lvl <= lvl + 1'b1;
            end
          end else if (cmd_r == CMD_MAP) begin
            if (lvl == LVL_LEAF) begin
              leaf_present <= 1'b1;
              leaf_user <= usr_r;
              leaf_write <= wr_r;
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              if (!present) begin
                nfp <= nfp + 1'b1;
                page <= nfp[PW-1:0];
              end else begin
                page <= frame_pg;
              end
              lvl <= lvl + 1'b1;
            end
          end else begin
            if (lvl == LVL_LEAF) begin
              leaf_present <= (cmd_r == CMD_UNMAP) ? 1'b0 : ram_rdata[0];
              leaf_user <= ram_rdata[2];
              leaf_write <= ram_rdata[1];
              if (cmd_r == CMD_TRANSLATE) begin
                phys_result <= {ram_rdata[ENTRY_W-1:3], va_r[OFFSET_W-1:0]};
              end
              done <= 1'b1;
              state <= S_IDLE;
            end else if (!present) begin
              status <= ST_NOT_MAPPED;
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              page <= frame_pg;
              lvl <= lvl + 1'b1;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_EVAL))
    else $error("store written outside clear or evaluate");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    int'(nfp) <= TABLE_PAGES)
    else $error("page pool overran the store");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (phys_result == '0 && !leaf_present))
    else $error("failed item carries data");

endmodule

[rtl/four_level_page_table_manager.sv]
// Top level of the four-level page table manager: root register, table store and walker.
// After reset the block clears its table store, one entry per cycle, with busy
// high. An item then passes a read state and an evaluate state per table level
// visited, as each level is a dependent read of the store's one registered read
// port: unmap and translate walk to the leaf or stop at an entry not present, a
// map makes a check walk followed by the rewriting walk, and an unknown command
// finishes without a walk. Each result appears for one cycle with done high and
// must be taken then; busy is low again in that cycle.
module four_level_page_table_manager import fptm_pkg::*; #(
  parameter int TABLE_PAGES = 64,
  parameter int ROOT_PAGES = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      cmd,
  input  logic [VA_W-1:0] virt_addr,
  input  logic [PA_W-1:0] phys_addr,
  input  logic            user_flag,
  input  logic            write_flag,
  output logic            done,
  output logic [1:0]      status,
  output logic [PA_W-1:0] phys_result,
  output logic            leaf_present,
  output logic            leaf_user,
  output logic            leaf_write,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_data
);

  localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int AW = $clog2(DEPTH);

  logic [1:0]         root_page;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_page <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_page <= cfg_data;
    end
  end

  fptm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  fptm_walker #(
    .TABLE_PAGES(TABLE_PAGES),
    .ROOT_PAGES (ROOT_PAGES)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .virt_addr   (virt_addr),
    .phys_addr   (phys_addr),
    .user_flag   (user_flag),
    .write_flag  (write_flag),
    .root_page   (root_page),
    .done        (done),
    .status      (status),
    .phys_result (phys_result),
    .leaf_present(leaf_present),
    .leaf_user   (leaf_user),
    .leaf_write  (leaf_write),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

endmodule
